// ----- design/fold_md5_pow_search_top_defines.svh -----
`ifndef FOLD_MD5_POW_SEARCH_TOP_DEFINES_SVH
`define FOLD_MD5_POW_SEARCH_TOP_DEFINES_SVH
// Assertion helpers
`define FMP_ASSERT_IMP(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) else $error("check failed");
`define FMP_ASSERT_NXT(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) else $error("check failed");
`endif

// ----- design/fmp_pkg.sv -----
package fmp_pkg;
    localparam int ROW_CHARS = 128;
    localparam int ROW_W     = $clog2(ROW_CHARS);
    localparam logic [29:0] COUNTER_MAX  = 30'd899999999;
    localparam logic [29:0] COUNTER_BASE = 30'd100000000;

    localparam logic [1:0] OP_WRITE   = 2'd0;
    localparam logic [1:0] OP_HASH    = 2'd1;
    localparam logic [1:0] OP_RESTART = 2'd2;

    localparam logic [1:0] REG_TGT_HI  = 2'd0;
    localparam logic [1:0] REG_TGT_LO  = 2'd1;
    localparam logic [1:0] REG_BEST_HI = 2'd2;
    localparam logic [1:0] REG_BEST_LO = 2'd3;

    typedef struct packed {
        logic [1:0]  op;
        logic [6:0]  position;
        logic [6:0]  seed_char;
        logic [29:0] counter;
    } t_in_item;

    typedef struct packed {
        logic [63:0] digest_high;
        logic [63:0] digest_low;
        logic [63:0] diff_high;
        logic [63:0] diff_low;
        logic        new_best;
        logic        bad_counter;
    } t_out_item;

    // controller -> datapath
    typedef struct packed {
        logic wr_char;
        logic restart;
        logic digit_start;
        logic digit_step;
        logic fold_load;
        logic fold_step;
        logic hex_make;
        logic md5_step;
        logic md5_fin;
        logic diff_make;
        logic res_bad;
        logic res_load;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic digits_done;
        logic fold_done;
        logic md5_done;
    } t_sts;

    localparam logic [31:0] MD5_K [64] = '{
        32'hd76aa478,32'he8c7b756,32'h242070db,32'hc1bdceee,32'hf57c0faf,32'h4787c62a,
        32'ha8304613,32'hfd469501,32'h698098d8,32'h8b44f7af,32'hffff5bb1,32'h895cd7be,
        32'h6b901122,32'hfd987193,32'ha679438e,32'h49b40821,32'hf61e2562,32'hc040b340,
        32'h265e5a51,32'he9b6c7aa,32'hd62f105d,32'h02441453,32'hd8a1e681,32'he7d3fbc8,
        32'h21e1cde6,32'hc33707d6,32'hf4d50d87,32'h455a14ed,32'ha9e3e905,32'hfcefa3f8,
        32'h676f02d9,32'h8d2a4c8a,32'hfffa3942,32'h8771f681,32'h6d9d6122,32'hfde5380c,
        32'ha4beea44,32'h4bdecfa9,32'hf6bb4b60,32'hbebfbc70,32'h289b7ec6,32'heaa127fa,
        32'hd4ef3085,32'h04881d05,32'hd9d4d039,32'he6db99e5,32'h1fa27cf8,32'hc4ac5665,
        32'hf4292244,32'h432aff97,32'hab9423a7,32'hfc93a039,32'h655b59c3,32'h8f0ccc92,
        32'hffeff47d,32'h85845dd1,32'h6fa87e4f,32'hfe2ce6e0,32'ha3014314,32'h4e0811a1,
        32'hf7537e82,32'hbd3af235,32'h2ad7d2bb,32'heb86d391
    };

    localparam logic [4:0] MD5_S [16] = '{
        5'd7,5'd12,5'd17,5'd22,5'd5,5'd9,5'd14,5'd20,
        5'd4,5'd11,5'd16,5'd23,5'd6,5'd10,5'd15,5'd21
    };

    // sum of two 7-bit chars, max 254: at most two subtractions of 95
    function automatic logic [6:0] fold2(input logic [7:0] v);
        logic [7:0] t;
        t = v;
        if (t > 8'd126) t = t - 8'd95;
        if (t > 8'd126) t = t - 8'd95;
        return t[6:0];
    endfunction

    // sum of four chars, max 508: at most five subtractions
    function automatic logic [3:0] fold4(input logic [8:0] v);
        logic [8:0] t;
        t = v;
        for (int k = 0; k < 5; k++) begin
            if (t > 9'd126) t = t - 9'd95;
        end
        return t[3:0];
    endfunction

    function automatic logic [7:0] hex_ascii(input logic [3:0] n);
        return (n < 4'd10) ? (8'h30 + {4'd0, n}) : (8'h37 + {4'd0, n});
    endfunction
endpackage

// ----- design/fmp_ctrl.sv -----
module fmp_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  fmp_pkg::t_in_item    i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output fmp_pkg::t_cmd        o_cmd,
    input  fmp_pkg::t_sts        i_sts
);
    import fmp_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_DIGIT = 7'b0000010,
        S_FOLD  = 7'b0000100,
        S_HEX   = 7'b0001000,
        S_MD5   = 7'b0010000,
        S_DIFF  = 7'b0100000,
        S_FIN   = 7'b1000000
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   in_acc;

    assign in_acc      = i_in_valid && !o_in_stall;
    assign o_in_stall  = (r_state != S_IDLE) || (r_out_valid && i_out_stall);
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && i_out_stall;
        o_cmd       = '0;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    case (i_in_data.op)
                        OP_WRITE:   o_cmd.wr_char = 1'b1;
                        OP_RESTART: o_cmd.restart = 1'b1;
                        OP_HASH: begin
                            if (i_in_data.counter > COUNTER_MAX) begin
                                o_cmd.res_bad = 1'b1;
                                n_out_valid   = 1'b1;
                            end else begin
                                o_cmd.digit_start = 1'b1;
                                n_state           = S_DIGIT;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_DIGIT: begin
                o_cmd.digit_step = 1'b1;
                if (i_sts.digits_done) begin
                    o_cmd.fold_load = 1'b1;
                    n_state         = S_FOLD;
                end
            end
            S_FOLD: begin
                o_cmd.fold_step = 1'b1;
                if (i_sts.fold_done) n_state = S_HEX;
            end
            S_HEX: begin
                o_cmd.hex_make = 1'b1;
                n_state        = S_MD5;
            end
            S_MD5: begin
                o_cmd.md5_step = 1'b1;
                if (i_sts.md5_done) n_state = S_DIFF;
            end
            S_DIFF: begin
                o_cmd.md5_fin = 1'b1;
                n_state       = S_FIN;
            end
            S_FIN: begin
                o_cmd.diff_make = 1'b1;
                o_cmd.res_load  = 1'b1;
                n_out_valid     = 1'b1;
                n_state         = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

`include "fold_md5_pow_search_top_defines.svh"
    `FMP_ASSERT_IMP(a_busy_stalls, i_clk, i_rst_n, r_state != S_IDLE, o_in_stall)
    `FMP_ASSERT_NXT(a_fin_valid, i_clk, i_rst_n, r_state == S_FIN, r_out_valid)
    `FMP_ASSERT_IMP(a_no_valid_busy, i_clk, i_rst_n, r_state == S_FOLD, !r_out_valid)
endmodule

// ----- design/fmp_datapath.sv -----
module fmp_datapath (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  fmp_pkg::t_in_item    i_in_data,
    input  fmp_pkg::t_cmd        i_cmd,
    output fmp_pkg::t_sts        o_sts,
    input  logic [63:0]          i_target_high,
    input  logic [63:0]          i_target_low,
    input  logic [63:0]          i_start_high,
    input  logic [63:0]          i_start_low,
    input  logic                 i_out_stall,
    output fmp_pkg::t_out_item   o_out_data
);
    import fmp_pkg::*;

    logic [6:0]   r_row [ROW_CHARS];
    logic [6:0]   r_cur [ROW_CHARS];
    logic [29:0]  r_val;
    logic [3:0]   r_dig_cnt;
    logic [ROW_W:0] r_round;
    logic [5:0]   r_md5_cnt;
    logic [255:0] r_msg;
    logic [31:0]  r_a, r_b, r_c, r_d;
    logic [63:0]  r_dh, r_dl;
    logic [63:0]  r_best_hi, r_best_lo;
    t_out_item    r_out;

    logic [29:0]  q_div;
    logic [3:0]   q_rem;
    logic [31:0]  f_md5, t_sum, w_g, rot;
    logic [5:0]   rnd;
    logic [3:0]   g_idx;
    logic [4:0]   sh;
    logic [63:0]  fh, fl;
    logic [63:0]  dh_n, dl_n;
    logic [31:0]  st0, st1, st2, st3;
    logic         better;

    // divide by ten via reciprocal multiply; value < 2^30
    logic [63:0]  prod;
    assign prod  = {34'd0, r_val} * 64'd3435973837;
    assign q_div = prod[63:35] > 29'h1FFFFFFF ? 30'd0 : {1'b0, prod[63:35]};
    assign q_rem = 4'(r_val - (q_div * 30'd10));

    assign rnd   = r_md5_cnt;
    always_comb begin
        case (rnd[5:4])
            2'd0: begin
                f_md5 = (r_b & r_c) | (~r_b & r_d);
                g_idx = rnd[3:0];
            end
            2'd1: begin
                f_md5 = (r_d & r_b) | (~r_d & r_c);
                g_idx = 4'(5 * rnd + 1);
            end
            2'd2: begin
                f_md5 = r_b ^ r_c ^ r_d;
                g_idx = 4'(3 * rnd + 5);
            end
            default: begin
                f_md5 = r_c ^ (r_b | ~r_d);
                g_idx = 4'(7 * rnd);
            end
        endcase
    end

    // message word: 32 ASCII bytes, 0x80, zeros, length 256 bits
    always_comb begin
        if (g_idx < 4'd8) begin
            w_g = r_msg[255 - 32 * g_idx -: 32];
            w_g = {w_g[7:0], w_g[15:8], w_g[23:16], w_g[31:24]};
        end else if (g_idx == 4'd8) begin
            w_g = 32'h00000080;
        end else if (g_idx == 4'd14) begin
            w_g = 32'h00000100;
        end else begin
            w_g = 32'd0;
        end
    end

    assign t_sum = r_a + f_md5 + MD5_K[rnd] + w_g;
    assign sh    = MD5_S[{rnd[5:4], rnd[1:0]}];
    assign rot   = (t_sum << sh) | (t_sum >> (6'd32 - {1'b0, sh}));

    assign st0 = 32'h67452301 + r_a;
    assign st1 = 32'hefcdab89 + r_b;
    assign st2 = 32'h98badcfe + r_c;
    assign st3 = 32'h10325476 + r_d;
    assign dh_n = {st0[7:0], st0[15:8], st0[23:16], st0[31:24],
                   st1[7:0], st1[15:8], st1[23:16], st1[31:24]};
    assign dl_n = {st2[7:0], st2[15:8], st2[23:16], st2[31:24],
                   st3[7:0], st3[15:8], st3[23:16], st3[31:24]};

    always_comb begin
        for (int k = 0; k < 16; k++) begin
            fh[4*k +: 4] = (r_dh[4*k +: 4] >= i_target_high[4*k +: 4]) ?
                r_dh[4*k +: 4] - i_target_high[4*k +: 4] :
                i_target_high[4*k +: 4] - r_dh[4*k +: 4];
            fl[4*k +: 4] = (r_dl[4*k +: 4] >= i_target_low[4*k +: 4]) ?
                r_dl[4*k +: 4] - i_target_low[4*k +: 4] :
                i_target_low[4*k +: 4] - r_dl[4*k +: 4];
        end
    end
    assign better = (fh < r_best_hi) || (fh == r_best_hi && fl < r_best_lo);

    assign o_sts.digits_done = (r_dig_cnt == 4'd9);
    assign o_sts.fold_done   = (r_round == (ROW_W + 1)'(ROW_CHARS - 1));
    assign o_sts.md5_done    = (r_md5_cnt == 6'd63);
    assign o_out_data        = r_out;

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_char) r_row[i_in_data.position] <= i_in_data.seed_char;
        if (i_cmd.digit_start) begin
            r_val     <= i_in_data.counter + COUNTER_BASE;
            r_dig_cnt <= '0;
        end
        if (i_cmd.digit_step && r_dig_cnt != 4'd9) begin
            r_row[ROW_W'(5'd17 - {1'b0, r_dig_cnt})] <= 7'h30 + {3'd0, q_rem};
            r_val     <= q_div;
            r_dig_cnt <= r_dig_cnt + 4'd1;
        end
        if (i_cmd.fold_load) begin
            r_cur   <= r_row;
            r_round <= '0;
        end
        if (i_cmd.fold_step) begin
            for (int k = 0; k < ROW_CHARS; k++) begin
                r_cur[k] <= fold2({1'b0, r_cur[k]} +
                                  {1'b0, r_cur[ROW_W'(k + 1)]});
            end
            r_round <= r_round + 1'b1;
        end
        if (i_cmd.hex_make) begin
            for (int k = 0; k < 32; k++) begin
                r_msg[255 - 8 * k -: 8] <= hex_ascii(fold4(
                    {2'd0, r_cur[4*k]} + {2'd0, r_cur[4*k+1]} +
                    {2'd0, r_cur[4*k+2]} + {2'd0, r_cur[4*k+3]}));
            end
            r_a <= 32'h67452301;
            r_b <= 32'hefcdab89;
            r_c <= 32'h98badcfe;
            r_d <= 32'h10325476;
            r_md5_cnt <= '0;
        end
        if (i_cmd.md5_step) begin
            r_a <= r_d;
            r_d <= r_c;
            r_c <= r_b;
            r_b <= r_b + rot;
            r_md5_cnt <= r_md5_cnt + 6'd1;
        end
        if (i_cmd.md5_fin) begin
            r_dh <= dh_n;
            r_dl <= dl_n;
        end
        if (i_cmd.res_bad && !i_out_stall) r_out <= '{default: '0, bad_counter: 1'b1};
        else if (i_cmd.res_bad)             r_out <= '{default: '0, bad_counter: 1'b1};
        if (i_cmd.res_load) begin
            r_out.digest_high <= r_dh;
            r_out.digest_low  <= r_dl;
            r_out.diff_high   <= fh;
            r_out.diff_low    <= fl;
            r_out.new_best    <= better;
            r_out.bad_counter <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_best_hi <= '1;
            r_best_lo <= '1;
        end else if (i_cmd.restart) begin
            r_best_hi <= i_start_high;
            r_best_lo <= i_start_low;
        end else if (i_cmd.diff_make && better) begin
            r_best_hi <= fh;
            r_best_lo <= fl;
        end
    end
endmodule

// ----- design/fmp_regs.sv -----
module fmp_regs (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready,
    output logic [63:0] o_target_high,
    output logic [63:0] o_target_low,
    output logic [63:0] o_start_high,
    output logic [63:0] o_start_low
);
    import fmp_pkg::*;

    logic [63:0] r_tgt_hi, r_tgt_lo, r_st_hi, r_st_lo;
    logic [1:0]  idx;
    logic        wr;

    assign idx    = paddr[4:3];
    assign wr     = psel && penable && pwrite;
    assign pready = 1'b1;

    always_comb begin
        case (idx)
            REG_TGT_HI:  prdata = r_tgt_hi;
            REG_TGT_LO:  prdata = r_tgt_lo;
            REG_BEST_HI: prdata = r_st_hi;
            default:     prdata = r_st_lo;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tgt_hi <= '0;
            r_tgt_lo <= '0;
            r_st_hi  <= '1;
            r_st_lo  <= '1;
        end else if (wr && paddr[2:0] == 3'd0) begin
            case (idx)
                REG_TGT_HI:  r_tgt_hi <= pwdata;
                REG_TGT_LO:  r_tgt_lo <= pwdata;
                REG_BEST_HI: r_st_hi  <= pwdata;
                default:     r_st_lo  <= pwdata;
            endcase
        end
    end

    assign o_target_high = r_tgt_hi;
    assign o_target_low  = r_tgt_lo;
    assign o_start_high  = r_st_hi;
    assign o_start_low   = r_st_lo;
endmodule

// ----- design/fold_md5_pow_search_top.sv -----
// Seed write and restart: no result.
// Hash: digit conversion, 128 fold rounds, hex, 64 MD5 rounds, digest and difference,
// then the result; the next transaction is accepted only back in idle. The fold round loop
// and the single MD5 round unit set the hash time. A held result stalls the input.
// Bad counter: result in the cycle after acceptance.
// Synchronous active-low reset: registers to reset values, best to all ones, seed undefined.
module fold_md5_pow_search_top (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  fmp_pkg::t_in_item    i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output fmp_pkg::t_out_item   o_out_data,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [4:0]           paddr,
    input  logic [63:0]          pwdata,
    output logic [63:0]          prdata,
    output logic                 pready
);
    import fmp_pkg::*;

    t_cmd        cmd;
    t_sts        sts;
    logic [63:0] tgt_hi, tgt_lo, st_hi, st_lo;

    fmp_regs u_regs (
        .i_clk, .i_rst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
        .o_target_high(tgt_hi), .o_target_low(tgt_lo),
        .o_start_high(st_hi), .o_start_low(st_lo)
    );

    fmp_ctrl u_ctrl (
        .i_clk, .i_rst_n, .i_in_valid, .o_in_stall, .i_in_data,
        .o_out_valid, .i_out_stall, .o_cmd(cmd), .i_sts(sts)
    );

    fmp_datapath u_dp (
        .i_clk, .i_rst_n, .i_in_data, .i_cmd(cmd), .o_sts(sts),
        .i_target_high(tgt_hi), .i_target_low(tgt_lo),
        .i_start_high(st_hi), .i_start_low(st_lo),
        .i_out_stall, .o_out_data
    );
endmodule

// ----- dv/fold_md5_pow_search_checker.sv -----
module fold_md5_pow_search_checker (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_in_stall,
    input  fmp_pkg::t_in_item   i_in_data,
    input  logic                i_out_valid,
    input  logic                i_out_stall,
    input  fmp_pkg::t_out_item  i_out_data,
    input  logic                i_psel,
    input  logic                i_penable,
    input  logic                i_pwrite,
    input  logic                i_pready,
    input  logic [4:0]          i_paddr,
    input  logic [63:0]         i_pwdata,
    output int                  o_fail_cnt,
    output int                  o_pending
);
    import fmp_pkg::*;

    logic [6:0]  seed_row [ROW_CHARS];
    logic [63:0] target_hi, target_lo, start_hi, start_lo;
    logic [63:0] best_hi, best_lo;
    t_out_item   expected_q [$];

    function automatic logic [7:0] fold_char(input int unsigned v);
        while (v > 126) v = v - 95;
        return v[7:0];
    endfunction

    function automatic logic [31:0] bswap(input logic [31:0] x);
        return {x[7:0], x[15:8], x[23:16], x[31:24]};
    endfunction

    function automatic t_out_item hash_counter(input logic [29:0] cnt);
        t_out_item   r;
        logic [7:0]  cur [ROW_CHARS];
        logic [7:0]  nxt [ROW_CHARS];
        logic [7:0]  hx [32];
        logic [31:0] w [16];
        logic [31:0] a, b, c, d, f, t, x;
        logic [3:0]  nib, dn, tn;
        int unsigned v, g, s;
        r = '0;
        if (cnt > COUNTER_MAX) begin
            r.bad_counter = 1'b1;
            return r;
        end
        v = cnt + 100000000;
        for (int i = 17; i >= 9; i--) begin
            seed_row[i] = 7'(48 + v % 10);
            v = v / 10;
        end
        for (int i = 0; i < ROW_CHARS; i++) cur[i] = {1'b0, seed_row[i]};
        for (int rd = 0; rd < ROW_CHARS; rd++) begin
            for (int i = 0; i < ROW_CHARS; i++)
                nxt[i] = fold_char(32'(cur[i]) + cur[(i + 1) % ROW_CHARS]);
            cur = nxt;
        end
        for (int i = 0; i < 32; i++) begin
            x = fold_char(32'(cur[4*i]) + cur[4*i+1] + cur[4*i+2] + cur[4*i+3]);
            nib = x[3:0];
            hx[i] = (nib < 10) ? 8'd48 + nib : 8'd55 + nib;
        end
        for (int i = 0; i < 16; i++) w[i] = '0;
        for (int i = 0; i < 8; i++) w[i] = {hx[4*i+3], hx[4*i+2], hx[4*i+1], hx[4*i]};
        w[8]  = 32'h80;
        w[14] = 32'h100;
        a = 32'h67452301; b = 32'hefcdab89; c = 32'h98badcfe; d = 32'h10325476;
        for (int i = 0; i < 64; i++) begin
            if (i < 16) begin
                f = (b & c) | (~b & d); g = i;
            end else if (i < 32) begin
                f = (d & b) | (~d & c); g = (5*i + 1) & 15;
            end else if (i < 48) begin
                f = b ^ c ^ d; g = (3*i + 5) & 15;
            end else begin
                f = c ^ (b | ~d); g = (7*i) & 15;
            end
            s = MD5_S[((i >> 4) << 2) | (i & 3)];
            x = a + f + MD5_K[i] + w[g];
            t = d; d = c; c = b;
            b = b + ((x << s) | (x >> (32 - s)));
            a = t;
        end
        r.digest_high = {bswap(32'h67452301 + a), bswap(32'hefcdab89 + b)};
        r.digest_low  = {bswap(32'h98badcfe + c), bswap(32'h10325476 + d)};
        for (int i = 0; i < 16; i++) begin
            dn = r.digest_high[4*i +: 4]; tn = target_hi[4*i +: 4];
            r.diff_high[4*i +: 4] = (dn >= tn) ? dn - tn : tn - dn;
            dn = r.digest_low[4*i +: 4];  tn = target_lo[4*i +: 4];
            r.diff_low[4*i +: 4]  = (dn >= tn) ? dn - tn : tn - dn;
        end
        if ({r.diff_high, r.diff_low} < {best_hi, best_lo}) begin
            best_hi = r.diff_high;
            best_lo = r.diff_low;
            r.new_best = 1'b1;
        end
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_out_item e;
        if (!i_rst_n) begin
            target_hi = '0; target_lo = '0;
            start_hi = '1; start_lo = '1;
            best_hi = '1; best_lo = '1;
            expected_q.delete();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (i_paddr[4:3])
                    REG_TGT_HI:  target_hi = i_pwdata;
                    REG_TGT_LO:  target_lo = i_pwdata;
                    REG_BEST_HI: start_hi = i_pwdata;
                    default:     start_lo = i_pwdata;
                endcase
            end
            if (i_in_valid && !i_in_stall) begin
                case (i_in_data.op)
                    OP_WRITE:   seed_row[i_in_data.position] = i_in_data.seed_char;
                    OP_RESTART: begin
                        best_hi = start_hi;
                        best_lo = start_lo;
                    end
                    OP_HASH:    expected_q.insert(expected_q.size(),
                                                  hash_counter(i_in_data.counter));
                    default: ;
                endcase
            end
            if (i_out_valid && !i_out_stall) begin
                if (expected_q.size() == 0) begin
                    $error("unexpected result transaction");
                    o_fail_cnt++;
                end else begin
                    e = expected_q.pop_front();
                    if (e.digest_high !== i_out_data.digest_high) begin
                        $error("digest_high exp %h got %h", e.digest_high,
                               i_out_data.digest_high);
                        o_fail_cnt++;
                    end
                    if (e.digest_low !== i_out_data.digest_low) begin
                        $error("digest_low exp %h got %h", e.digest_low, i_out_data.digest_low);
                        o_fail_cnt++;
                    end
                    if (e.diff_high !== i_out_data.diff_high) begin
                        $error("diff_high exp %h got %h", e.diff_high, i_out_data.diff_high);
                        o_fail_cnt++;
                    end
                    if (e.diff_low !== i_out_data.diff_low) begin
                        $error("diff_low exp %h got %h", e.diff_low, i_out_data.diff_low);
                        o_fail_cnt++;
                    end
                    if (e.new_best !== i_out_data.new_best) begin
                        $error("new_best exp %b got %b", e.new_best, i_out_data.new_best);
                        o_fail_cnt++;
                    end
                    if (e.bad_counter !== i_out_data.bad_counter) begin
                        $error("bad_counter exp %b got %b", e.bad_counter,
                               i_out_data.bad_counter);
                        o_fail_cnt++;
                    end
                end
            end
        end
        o_pending = expected_q.size();
    end

endmodule

// ----- dv/tb_fold_md5_pow_search_top.sv -----
module tb_fold_md5_pow_search_top;
    import fmp_pkg::*;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    t_in_item    i_in_data = '0;
    logic        i_out_stall = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [4:0]  paddr = '0;
    logic [63:0] pwdata = '0;
    logic        o_in_stall, o_out_valid, pready;
    t_out_item   o_out_data;
    logic [63:0] prdata;
    int          fail_cnt, pending;
    int          in_pct = 0, out_pct = 0;
    bit          hold_req = 1'b0, hold_done = 1'b0;
    int          hold_left = 0;

    fold_md5_pow_search_top dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall), .i_in_data(i_in_data),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall), .o_out_data(o_out_data),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    fold_md5_pow_search_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .i_in_stall(o_in_stall), .i_in_data(i_in_data),
        .i_out_valid(o_out_valid), .i_out_stall(i_out_stall), .i_out_data(o_out_data),
        .i_psel(psel), .i_penable(penable), .i_pwrite(pwrite), .i_pready(pready),
        .i_paddr(paddr), .i_pwdata(pwdata),
        .o_fail_cnt(fail_cnt), .o_pending(pending)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // long hold-off on the result side so the block backs up
    always @(posedge i_clk) begin
        if (hold_left != 0) begin
            i_out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end else if (hold_req && !hold_done) begin
            i_out_stall <= 1'b1;
            hold_left <= 1500;
            hold_done <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < out_pct);
        end
    end

    initial begin
        #(12 * 3000000);
        $display("tb_fold_md5_pow_search_top: errors");
        $finish;
    end

    task automatic offer(input t_in_item it);
        while ($urandom_range(99) < in_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data <= it;
        @(negedge i_clk);
        while (o_in_stall) @(negedge i_clk);
        @(posedge i_clk);
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (220) @(posedge i_clk);
    endtask

    task automatic reg_write(input logic [1:0] idx, input logic [63:0] val);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= {idx, 3'b000}; pwdata <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_regs(input logic [63:0] th, tl, bh, bl);
        reg_write(REG_TGT_HI, th);
        reg_write(REG_TGT_LO, tl);
        reg_write(REG_BEST_HI, bh);
        reg_write(REG_BEST_LO, bl);
    endtask

    function automatic logic [6:0] rand_char();
        return ($urandom_range(9) == 0) ? 7'($urandom_range(127)) : 7'($urandom_range(126, 33));
    endfunction

    function automatic t_in_item mk(input logic [1:0] op, input logic [6:0] pos,
                                    input logic [6:0] ch, input logic [29:0] cnt);
        t_in_item it;
        it.op = op; it.position = pos; it.seed_char = ch; it.counter = cnt;
        return it;
    endfunction

    task automatic run_phase(input int n, input int ipct, input int opct);
        t_in_item it;
        int k, sel;
        in_pct = ipct;
        out_pct = opct;
        k = 0;
        while (k < n) begin
            sel = $urandom_range(99);
            it = mk(OP_WRITE, 7'($urandom), rand_char(), 30'($urandom));
            if (sel < 30) begin
                it.op = OP_HASH;
                if ($urandom_range(9) == 0) it.counter = 30'($urandom_range(1073741823, 900000000));
                else it.counter = 30'($urandom_range(899999999));
            end else if (sel < 38) begin
                it.op = OP_RESTART;
            end else if (sel < 44) begin
                it.op = 2'd3;
            end
            if (it.op != 2'd3) k++;
            offer(it);
        end
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        set_regs('0, '0, '1, '1);

        // seed row, extremes at the ends and out-of-range characters
        for (int p = 0; p < ROW_CHARS; p++) begin
            logic [6:0] ch;
            ch = 7'($urandom_range(126, 33));
            if (p == 0) ch = 7'd33;
            if (p == 127) ch = 7'd126;
            if (p == 5) ch = 7'd0;
            if (p == 6) ch = 7'd127;
            offer(mk(OP_WRITE, 7'(p), ch, 30'($urandom)));
        end
        offer(mk(OP_HASH, 7'($urandom), 7'($urandom), 30'd0));
        offer(mk(OP_HASH, 7'($urandom), 7'($urandom), 30'd899999999));
        offer(mk(OP_HASH, 7'($urandom), 7'($urandom), 30'd900000000));
        offer(mk(OP_HASH, 7'($urandom), 7'($urandom), 30'h3FFFFFFF));
        offer(mk(OP_HASH, 7'($urandom), 7'($urandom), 30'd123456789));
        offer(mk(2'd3, 7'h7F, 7'h7F, 30'h3FFFFFFF));
        offer(mk(OP_RESTART, 7'($urandom), 7'($urandom), 30'($urandom)));
        offer(mk(OP_HASH, 7'($urandom), 7'($urandom), 30'd123456789));
        drain();

        run_phase(600, 21, 85);
        drain();
        set_regs('1, '1, '0, '0);
        offer(mk(OP_RESTART, 7'($urandom), 7'($urandom), 30'($urandom)));
        run_phase(600, 85, 21);
        drain();
        set_regs({$urandom, $urandom}, {$urandom, $urandom},
                 {4'h3, 28'($urandom), $urandom}, {$urandom, $urandom});
        offer(mk(OP_RESTART, 7'($urandom), 7'($urandom), 30'($urandom)));
        hold_req <= 1'b1;
        run_phase(600, 0, 0);
        drain();

        if (fail_cnt == 0) begin
            $display("tb_fold_md5_pow_search_top: clean");
        end else begin
            $display("tb_fold_md5_pow_search_top: errors");
        end
        $finish;
    end

endmodule
